// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, codes and helpers for the scalar kalman tracker
// ----------------------------------------------------------------------------
package skt_pkg;

    // command codes carried in the input tuser
    typedef enum logic [1:0] {
        CMD_LOAD           = 2'd0,
        CMD_PREDICT        = 2'd1,
        CMD_UPDATE         = 2'd2,
        CMD_PREDICT_UPDATE = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;

    localparam logic [31:0] COV_ONE     = 32'h0001_0000;
    localparam logic [31:0] NOISE_RESET = 32'h0001_0000;
    localparam logic [16:0] GAIN_ONE    = 17'h1_0000;

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_PRED_MUL = 10'b00_0000_0010,
        ST_PRED_ADD = 10'b00_0000_0100,
        ST_UPD_DEN  = 10'b00_0000_1000,
        ST_UPD_DIV  = 10'b00_0001_0000,
        ST_UPD_MUL1 = 10'b00_0010_0000,
        ST_UPD_ADD  = 10'b00_0100_0000,
        ST_UPD_MUL2 = 10'b00_1000_0000,
        ST_UPD_COV  = 10'b01_0000_0000,
        ST_FINISH   = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] value;
    } sat_result_t;

    // clip a wide signed sum to the signed 32-bit range
    function automatic sat_result_t sat_pos(input logic signed [49:0] v);
        sat_result_t r;
        if (v > 50'sd2147483647) begin
            r.sat   = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r.sat   = 1'b1;
            r.value = 32'h8000_0000;
        end else begin
            r.sat   = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/scalar_kalman_tracker_core.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_tracker_core
// one-target constant-velocity kalman tracker, signed q16.16, shared unit
// ----------------------------------------------------------------------------
// usage
//   input stream s_axis: tuser carries the command (load, predict, update,
//   predict then update), tdata the time step, measurement and load values.
//   output stream m_axis: one item per input item with the position estimate
//   and error covariance in tdata and the saturation flag in tuser.
//   cfg_we/cfg_index/cfg_data write process noise (index 0) and measurement
//   noise (index 1); other indexes are ignored. write only while idle.
// timing
//   one item at a time; s_axis_tready is high only in the idle state.
//   load goes to the finish state; predict runs a multiply and an add;
//   update runs a denominator step, the 17-step restoring gain divider,
//   then correction and covariance steps. one shared 33x33 multiplier
//   forms the predict product, correction and covariance scale.
// reset
//   position and velocity clear, covariance returns to 1.0, both noise
//   registers return to 1.0 and the output register is empty.
// stalls
//   a finished result waits in the output register; a following item is
//   accepted and worked on, and holds in its last state until the register
//   frees.
// ----------------------------------------------------------------------------
module scalar_kalman_tracker_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_step [31:0], measurement [63:32], start_position [95:64],
    // start_velocity [127:96]
    input  logic [127:0] s_axis_tdata,
    // cmd [1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position_estimate [31:0], error_covariance [63:32]
    output logic [63:0]  m_axis_tdata,
    // saturated [0]
    output logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    skt_pkg::state_t state_reg, state_next;

    logic [31:0] q_noise_reg;
    logic [31:0] r_noise_reg;

    logic [31:0] pos_reg;
    logic [31:0] vel_reg;
    logic [31:0] cov_reg;
    logic        sat_reg;

    logic              upd_pending_reg;
    logic [31:0]       dt_reg;
    logic [31:0]       meas_reg;
    logic [32:0]       den_reg;
    logic [33:0]       rem_reg;
    logic [16:0]       quot_reg;
    logic [16:0]       gain_reg;
    logic [4:0]        cnt_reg;
    logic signed [32:0] innov_reg;
    logic signed [65:0] mul_reg;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_sat_reg;

    logic s_accept;
    logic out_free;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] pos_sum;
    logic [32:0]        cov_sum;
    logic               div_ge;
    logic [33:0]        rem_sub;
    logic [16:0]        quot_full;
    skt_pkg::sat_result_t pos_sat;

    assign s_axis_tready = (state_reg == skt_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            skt_pkg::ST_PRED_MUL:
            begin
                mul_a = {vel_reg[31], vel_reg};
                mul_b = {dt_reg[31], dt_reg};
            end
            skt_pkg::ST_UPD_MUL1:
            begin
                mul_a = {16'd0, gain_reg};
                mul_b = innov_reg;
            end
            skt_pkg::ST_UPD_MUL2:
            begin
                mul_a = {16'd0, skt_pkg::GAIN_ONE - gain_reg};
                mul_b = {1'b0, cov_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor of the q16 product is the top bits of the exact product
    assign pos_sum = {{18{pos_reg[31]}}, pos_reg} + mul_reg[65:16];
    assign pos_sat = skt_pkg::sat_pos(pos_sum);
    assign cov_sum = {1'b0, cov_reg} + {1'b0, q_noise_reg};

    // restoring divider step
    assign div_ge    = (rem_reg >= {1'b0, den_reg});
    assign rem_sub   = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign quot_full = {quot_reg[15:0], div_ge};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    priority case (skt_pkg::cmd_t'(s_axis_tuser))
                        skt_pkg::CMD_LOAD:    state_next = skt_pkg::ST_FINISH;
                        skt_pkg::CMD_UPDATE:  state_next = skt_pkg::ST_UPD_DEN;
                        default:              state_next = skt_pkg::ST_PRED_MUL;
                    endcase
                end
            end
            skt_pkg::ST_PRED_MUL: state_next = skt_pkg::ST_PRED_ADD;
            skt_pkg::ST_PRED_ADD:
                state_next = upd_pending_reg ? skt_pkg::ST_UPD_DEN : skt_pkg::ST_FINISH;
            skt_pkg::ST_UPD_DEN:  state_next = skt_pkg::ST_UPD_DIV;
            skt_pkg::ST_UPD_DIV:
                if (cnt_reg == 5'd0)
                    state_next = skt_pkg::ST_UPD_MUL1;
            skt_pkg::ST_UPD_MUL1: state_next = skt_pkg::ST_UPD_ADD;
            skt_pkg::ST_UPD_ADD:  state_next = skt_pkg::ST_UPD_MUL2;
            skt_pkg::ST_UPD_MUL2: state_next = skt_pkg::ST_UPD_COV;
            skt_pkg::ST_UPD_COV:  state_next = skt_pkg::ST_FINISH;
            skt_pkg::ST_FINISH:
                if (out_free)
                    state_next = skt_pkg::ST_IDLE;
            default:              state_next = skt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= skt_pkg::ST_IDLE;
            q_noise_reg     <= skt_pkg::NOISE_RESET;
            r_noise_reg     <= skt_pkg::NOISE_RESET;
            pos_reg         <= '0;
            vel_reg         <= '0;
            cov_reg         <= skt_pkg::COV_ONE;
            sat_reg         <= 1'b0;
            upd_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && cfg_index == skt_pkg::REG_PROCESS_NOISE)
                q_noise_reg <= cfg_data;
            if (cfg_we && cfg_index == skt_pkg::REG_MEASUREMENT_NOISE)
                r_noise_reg <= cfg_data;

            // result register loads in the finish state, drains on ready
            if (state_reg == skt_pkg::ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                skt_pkg::ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        sat_reg         <= 1'b0;
                        upd_pending_reg <= s_axis_tuser[1];
                        if (skt_pkg::cmd_t'(s_axis_tuser) == skt_pkg::CMD_LOAD)
                        begin
                            pos_reg <= s_axis_tdata[95:64];
                            vel_reg <= s_axis_tdata[127:96];
                            cov_reg <= skt_pkg::COV_ONE;
                        end
                    end
                end
                skt_pkg::ST_PRED_ADD:
                begin
                    pos_reg <= pos_sat.value;
                    if (cov_sum[32])
                        cov_reg <= 32'hFFFF_FFFF;
                    else
                        cov_reg <= cov_sum[31:0];
                    sat_reg <= sat_reg | pos_sat.sat | cov_sum[32];
                end
                skt_pkg::ST_UPD_ADD:
                begin
                    pos_reg <= pos_sat.value;
                    sat_reg <= sat_reg | pos_sat.sat;
                end
                skt_pkg::ST_UPD_COV:
                    cov_reg <= mul_reg[47:16];
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            dt_reg   <= s_axis_tdata[31:0];
            meas_reg <= s_axis_tdata[63:32];
        end

        mul_reg <= mul_a * mul_b;

        if (state_reg == skt_pkg::ST_UPD_DEN)
        begin
            den_reg   <= {1'b0, cov_reg} + {1'b0, r_noise_reg};
            rem_reg   <= {2'b00, cov_reg};
            quot_reg  <= '0;
            cnt_reg   <= 5'd16;
            innov_reg <= $signed({meas_reg[31], meas_reg}) - $signed({pos_reg[31], pos_reg});
        end

        if (state_reg == skt_pkg::ST_UPD_DIV)
        begin
            rem_reg  <= {rem_sub[32:0], 1'b0};
            quot_reg <= quot_full;
            cnt_reg  <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                // zero denominator gives zero gain
                if (den_reg == 33'd0)
                    gain_reg <= '0;
                else
                    gain_reg <= quot_full;
            end
        end

        if (state_reg == skt_pkg::ST_FINISH && out_free)
        begin
            out_data_reg <= {cov_reg, pos_reg};
            out_sat_reg  <= sat_reg;
        end
    end

endmodule

// ----- hdl/skt_checker.sv -----
// ----------------------------------------------------------------------------
// skt_checker
// port-level checks for the scalar kalman tracker, bound to the top level
// ----------------------------------------------------------------------------
module skt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         m_axis_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output item changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a new result comes only from work started while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without an item in work");

    // load with a free output shows the loaded position and unit covariance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && s_axis_tuser == skt_pkg::CMD_LOAD
            && (!m_axis_tvalid || m_axis_tready)
        |=> ##1 m_axis_tvalid && !m_axis_tuser
            && m_axis_tdata[31:0] == $past(s_axis_tdata[95:64], 2)
            && m_axis_tdata[63:32] == skt_pkg::COV_ONE)
        else $error("load result wrong");

endmodule

bind scalar_kalman_tracker_core skt_checker u_skt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
